@@ hw/rtl/ips_pkg.sv @@
// shared widths and default sizes for the interval partition scheduler
package ips_pkg;

  // default sizes handed to the top level parameters
  localparam int unsigned MAX_JOBS_DEF  = 16;
  localparam int unsigned TIME_BITS_DEF = 16;

  // fixed port widths
  localparam int unsigned IN_TIME_W  = 16;
  localparam int unsigned OUT_TIME_W = 16;
  localparam int unsigned ID_W       = 8;
  localparam int unsigned ROW_W      = 6;

endpackage

@@ hw/rtl/ips_job_mem.sv @@
// job store: start, finish and id per load slot, one write and one registered read port
module ips_job_mem import ips_pkg::*; #(
  parameter int unsigned MAX_JOBS  = MAX_JOBS_DEF,
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [$clog2(MAX_JOBS)-1:0] waddr_i,
  input  logic [TIME_BITS-1:0]        wstart_i,
  input  logic [TIME_BITS-1:0]        wfinish_i,
  input  logic [ID_W-1:0]             wid_i,
  input  logic [$clog2(MAX_JOBS)-1:0] raddr_i,
  output logic [TIME_BITS-1:0]        rstart_o,
  output logic [TIME_BITS-1:0]        rfinish_o,
  output logic [ID_W-1:0]             rid_o
);

  localparam int unsigned EntW = 2 * TIME_BITS + ID_W;

  logic [EntW-1:0] mem_q [MAX_JOBS];
  logic [EntW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= {wstart_i, wfinish_i, wid_i};
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rstart_o  = rdata_q[EntW-1 -: TIME_BITS];
  assign rfinish_o = rdata_q[ID_W +: TIME_BITS];
  assign rid_o     = rdata_q[ID_W-1:0];

endmodule

@@ hw/rtl/ips_order_mem.sv @@
// sorted order store: load slot per sorted position, registered read
module ips_order_mem import ips_pkg::*; #(
  parameter int unsigned MAX_JOBS = MAX_JOBS_DEF
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [$clog2(MAX_JOBS)-1:0] waddr_i,
  input  logic [$clog2(MAX_JOBS)-1:0] wdata_i,
  input  logic [$clog2(MAX_JOBS)-1:0] raddr_i,
  output logic [$clog2(MAX_JOBS)-1:0] rdata_o
);

  localparam int unsigned IdxW = $clog2(MAX_JOBS);

  logic [IdxW-1:0] mem_q [MAX_JOBS];
  logic [IdxW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/interval_partition_scheduler_unit.sv @@
// top level of the interval partition scheduler: load, rank sort and greedy row passes
//
// channel   direction  handshake                      payload
// --------  ---------  -----------------------------  -----------------------------------------
// request   in         start_i high, busy_o low       start_time_i finish_time_i job_id_i
//                                                     last_job_i
// result    out        valid_o, one cycle, no stall   out_job_id_o row_o out_start_o
//                                                     out_finish_o overflow_o last_result_o
//
// a request without last_job stores the job, or drops it once the store is full; busy_o stays low while jobs load
// the request with last_job starts scheduling: the rank sort reads each job and then scans all
// stored jobs (one job memory read per compare), then each greedy pass scans all n sorted slots
// at one slot a cycle through the order memory read and then the job memory read
// until every stored job is placed; the last result comes in the cycle after the last busy cycle
// reset clears control state and marks all jobs pending; memories are not cleared
// results cannot be stalled: each appears for exactly one cycle with valid_o
module interval_partition_scheduler_unit import ips_pkg::*; #(
  parameter int unsigned MAX_JOBS  = MAX_JOBS_DEF,
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [IN_TIME_W-1:0]  start_time_i,
  input  logic [IN_TIME_W-1:0]  finish_time_i,
  input  logic [ID_W-1:0]       job_id_i,
  input  logic                  last_job_i,
  output logic                  valid_o,
  output logic [ID_W-1:0]       out_job_id_o,
  output logic [ROW_W-1:0]      row_o,
  output logic [OUT_TIME_W-1:0] out_start_o,
  output logic [OUT_TIME_W-1:0] out_finish_o,
  output logic                  overflow_o,
  output logic                  last_result_o
);

  localparam int unsigned IdxW = $clog2(MAX_JOBS);
  localparam int unsigned CntW = $clog2(MAX_JOBS + 1);

  // controller states
  localparam logic [2:0] S_IDLE    = 3'd0;  // loading jobs
  localparam logic [2:0] S_RK_HEAD = 3'd1;  // read the job being ranked
  localparam logic [2:0] S_RK_CAP  = 3'd2;  // capture it, start the compare scan
  localparam logic [2:0] S_RK_SCAN = 3'd3;  // one compare per cycle
  localparam logic [2:0] S_PASS    = 3'd4;  // greedy passes

  // strict order: finish, then start, then load slot
  function automatic logic goes_before(input logic [TIME_BITS-1:0] s_a,
                                       input logic [TIME_BITS-1:0] f_a,
                                       input logic [IdxW-1:0]      x_a,
                                       input logic [TIME_BITS-1:0] s_b,
                                       input logic [TIME_BITS-1:0] f_b,
                                       input logic [IdxW-1:0]      x_b);
    logic res;
    if (f_a != f_b) begin
      res = f_a < f_b;
    end else if (s_a != s_b) begin
      res = s_a < s_b;
    end else begin
      res = x_a < x_b;
    end
    return res;
  endfunction

  logic [2:0]          state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;         // stored jobs
  logic                drop_q, drop_d;       // a job was dropped for capacity
  logic [CntW-1:0]     i_q, i_d;             // job being ranked
  logic [IdxW-1:0]     cmp_q, cmp_d;         // slot whose data arrives this cycle
  logic [IdxW-1:0]     rank_q, rank_d;
  logic [TIME_BITS-1:0] cur_s_q, cur_s_d, cur_f_q, cur_f_d;

  // pass pipeline: issue slot k, order read, job read, decide
  logic [IdxW-1:0]     k_q, k_d;
  logic                v1_q, v1_d, v2_q, v2_d;
  logic [IdxW-1:0]     k1_q, k1_d, k2_q, k2_d, j2_q, j2_d;
  logic [MAX_JOBS-1:0] pend_q, pend_d;
  logic [CntW-1:0]     placed_q, placed_d;
  logic [ROW_W-1:0]    pass_q, pass_d;
  logic                none_q, none_d;       // no job taken yet in this pass
  logic [TIME_BITS-1:0] last_f_q, last_f_d;

  logic                valid_q, valid_d, last_res_q, last_res_d;
  logic [ID_W-1:0]     out_id_q, out_id_d;
  logic [ROW_W-1:0]    out_row_q, out_row_d;
  logic [OUT_TIME_W-1:0] out_s_q, out_s_d, out_f_q, out_f_d;
  logic                out_ovf_q, out_ovf_d;

  // memory ports
  logic                jm_we;
  logic [IdxW-1:0]     jm_waddr, jm_raddr;
  logic [TIME_BITS-1:0] jm_rstart, jm_rfinish;
  logic [ID_W-1:0]     jm_rid;
  logic                om_we;
  logic [IdxW-1:0]     om_waddr, om_wdata, om_raddr, om_rdata;

  logic                is_ahead;
  logic [IdxW-1:0]     rank_new;
  logic                take;

  ips_job_mem #(
    .MAX_JOBS (MAX_JOBS),
    .TIME_BITS(TIME_BITS)
  ) u_job_mem (
    .clk_i    (clk_i),
    .we_i     (jm_we),
    .waddr_i  (jm_waddr),
    .wstart_i (TIME_BITS'(start_time_i)),
    .wfinish_i(TIME_BITS'(finish_time_i)),
    .wid_i    (job_id_i),
    .raddr_i  (jm_raddr),
    .rstart_o (jm_rstart),
    .rfinish_o(jm_rfinish),
    .rid_o    (jm_rid)
  );

  ips_order_mem #(
    .MAX_JOBS(MAX_JOBS)
  ) u_order_mem (
    .clk_i  (clk_i),
    .we_i   (om_we),
    .waddr_i(om_waddr),
    .wdata_i(om_wdata),
    .raddr_i(om_raddr),
    .rdata_o(om_rdata)
  );

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    drop_d     = drop_q;
    i_d        = i_q;
    cmp_d      = cmp_q;
    rank_d     = rank_q;
    cur_s_d    = cur_s_q;
    cur_f_d    = cur_f_q;
    k_d        = k_q;
    v1_d       = 1'b0;
    v2_d       = 1'b0;
    k1_d       = k1_q;
    k2_d       = k2_q;
    j2_d       = j2_q;
    pend_d     = pend_q;
    placed_d   = placed_q;
    pass_d     = pass_q;
    none_d     = none_q;
    last_f_d   = last_f_q;
    valid_d    = 1'b0;
    last_res_d = 1'b0;
    out_id_d   = out_id_q;
    out_row_d  = out_row_q;
    out_s_d    = out_s_q;
    out_f_d    = out_f_q;
    out_ovf_d  = out_ovf_q;
    jm_we      = 1'b0;
    jm_waddr   = cnt_q[IdxW-1:0];
    jm_raddr   = cmp_q;
    om_we      = 1'b0;
    om_waddr   = rank_q;
    om_wdata   = i_q[IdxW-1:0];
    om_raddr   = k_q;
    is_ahead   = 1'b0;
    rank_new   = rank_q;
    take       = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (cnt_q < CntW'(MAX_JOBS)) begin
            jm_we = 1'b1;
            cnt_d = cnt_q + 1'b1;
          end else begin
            drop_d = 1'b1;
          end
          if (last_job_i) begin
            state_d = S_RK_HEAD;
            i_d     = '0;
          end
        end
      end

      S_RK_HEAD: begin
        jm_raddr = i_q[IdxW-1:0];
        state_d  = S_RK_CAP;
      end

      S_RK_CAP: begin
        cur_s_d  = jm_rstart;
        cur_f_d  = jm_rfinish;
        jm_raddr = '0;
        cmp_d    = '0;
        rank_d   = '0;
        state_d  = S_RK_SCAN;
      end

      S_RK_SCAN: begin
        // rank = number of stored jobs that go before the current one
        is_ahead = goes_before(jm_rstart, jm_rfinish, cmp_q,
                               cur_s_q, cur_f_q, i_q[IdxW-1:0]);
        rank_new = rank_q + IdxW'(is_ahead);
        rank_d   = rank_new;
        jm_raddr = cmp_q + 1'b1;
        cmp_d    = cmp_q + 1'b1;
        if (CntW'(cmp_q) + 1'b1 == cnt_q) begin
          om_we    = 1'b1;
          om_waddr = rank_new;
          i_d      = i_q + 1'b1;
          if (i_q + 1'b1 == cnt_q) begin
            state_d  = S_PASS;
            k_d      = '0;
            placed_d = '0;
            pass_d   = '0;
            none_d   = 1'b1;
          end else begin
            state_d = S_RK_HEAD;
          end
        end
      end

      S_PASS: begin
        // issue the next sorted slot, wrapping at the job count
        om_raddr = k_q;
        k_d      = (CntW'(k_q) + 1'b1 == cnt_q) ? '0 : k_q + 1'b1;
        v1_d     = 1'b1;
        k1_d     = k_q;
        v2_d     = v1_q;
        k2_d     = k1_q;
        j2_d     = om_rdata;
        jm_raddr = om_rdata;
        if (v2_q) begin
          take = pend_q[j2_q] && (none_q || (jm_rstart > last_f_q));
          if (take) begin
            pend_d[j2_q] = 1'b0;
            last_f_d     = jm_rfinish;
            none_d       = 1'b0;
            placed_d     = placed_q + 1'b1;
            valid_d      = 1'b1;
            out_id_d     = jm_rid;
            out_row_d    = pass_q;
            out_s_d      = OUT_TIME_W'(jm_rstart);
            out_f_d      = OUT_TIME_W'(jm_rfinish);
            out_ovf_d    = drop_q;
          end
          // end of a pass: next slot opens a new row
          if (CntW'(k2_q) + 1'b1 == cnt_q) begin
            pass_d = pass_q + 1'b1;
            none_d = 1'b1;
          end
          if (take && (placed_q + 1'b1 == cnt_q)) begin
            last_res_d = 1'b1;
            state_d    = S_IDLE;
            cnt_d      = '0;
            drop_d     = 1'b0;
            pend_d     = '1;
            v1_d       = 1'b0;
            v2_d       = 1'b0;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      drop_q     <= 1'b0;
      i_q        <= '0;
      cmp_q      <= '0;
      rank_q     <= '0;
      k_q        <= '0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      k1_q       <= '0;
      k2_q       <= '0;
      pend_q     <= '1;
      placed_q   <= '0;
      pass_q     <= '0;
      none_q     <= 1'b1;
      valid_q    <= 1'b0;
      last_res_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      drop_q     <= drop_d;
      i_q        <= i_d;
      cmp_q      <= cmp_d;
      rank_q     <= rank_d;
      k_q        <= k_d;
      v1_q       <= v1_d;
      v2_q       <= v2_d;
      k1_q       <= k1_d;
      k2_q       <= k2_d;
      pend_q     <= pend_d;
      placed_q   <= placed_d;
      pass_q     <= pass_d;
      none_q     <= none_d;
      valid_q    <= valid_d;
      last_res_q <= last_res_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cur_s_q   <= cur_s_d;
    cur_f_q   <= cur_f_d;
    j2_q      <= j2_d;
    last_f_q  <= last_f_d;
    out_id_q  <= out_id_d;
    out_row_q <= out_row_d;
    out_s_q   <= out_s_d;
    out_f_q   <= out_f_d;
    out_ovf_q <= out_ovf_d;
  end

  assign busy_o        = (state_q != S_IDLE);
  assign valid_o       = valid_q;
  assign last_result_o = last_res_q;
  assign out_job_id_o  = out_id_q;
  assign row_o         = out_row_q;
  assign out_start_o   = out_s_q;
  assign out_finish_o  = out_f_q;
  assign overflow_o    = out_ovf_q;

  // results only come out of the pass phase
  a_valid_from_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ($past(state_q) == S_PASS))
    else $error("result outside of pass phase");

  // the final result is a real result
  a_last_has_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_result_o |-> valid_o)
    else $error("last_result without valid");

  // scheduling never runs on an empty set
  a_pass_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PASS) |-> (cnt_q != '0))
    else $error("pass phase with no jobs");

  // the closing request makes the block busy
  a_last_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && last_job_i) |=> busy_o)
    else $error("last job did not start scheduling");

endmodule

@@ tb/ips_schedule_checker.sv @@
// checker for the interval partition scheduler: predicts row placements and compares results
module ips_schedule_checker import ips_pkg::*; #(
  parameter int unsigned MAX_JOBS = MAX_JOBS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  busy_i,
  input  logic [IN_TIME_W-1:0]  start_time_i,
  input  logic [IN_TIME_W-1:0]  finish_time_i,
  input  logic [ID_W-1:0]       job_id_i,
  input  logic                  last_job_i,
  input  logic                  valid_i,
  input  logic [ID_W-1:0]       out_job_id_i,
  input  logic [ROW_W-1:0]      row_i,
  input  logic [OUT_TIME_W-1:0] out_start_i,
  input  logic [OUT_TIME_W-1:0] out_finish_i,
  input  logic                  overflow_i,
  input  logic                  last_result_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    checked_o,
  output int                    sets_o,
  output int                    full_sets_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ID_W-1:0]       job_id;
    logic [ROW_W-1:0]      row;
    logic [OUT_TIME_W-1:0] start_t;
    logic [OUT_TIME_W-1:0] finish_t;
    logic                  overflow;
    logic                  last;
  } placement_t;

  placement_t placement_q[$];

  logic [IN_TIME_W-1:0] held_start  [MAX_JOBS];
  logic [IN_TIME_W-1:0] held_finish [MAX_JOBS];
  logic [ID_W-1:0]      held_id     [MAX_JOBS];
  int                   held_cnt;
  bit                   jobs_dropped;

  int fail_cnt, checked_cnt, set_cnt, full_set_cnt;

  assign fail_count_o = fail_cnt;
  assign checked_o    = checked_cnt;
  assign sets_o       = set_cnt;
  assign full_sets_o  = full_set_cnt;

  // strict order: finish, then start, then load position
  function automatic bit ranks_before(int a, int b);
    if (held_finish[a] != held_finish[b]) return held_finish[a] < held_finish[b];
    if (held_start[a] != held_start[b]) return held_start[a] < held_start[b];
    return a < b;
  endfunction

  // sort the held jobs, run greedy passes and queue one placement per job
  function automatic void plan_rows();
    int         order [MAX_JOBS];
    bit         taken [MAX_JOBS];
    int         j, idx, pass, placed, last_fin, s;
    placement_t rec;
    for (int i = 0; i < held_cnt; i++) begin
      j = i;
      while (j > 0 && ranks_before(i, order[j-1])) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
      taken[i] = 1'b0;
    end
    placed = 0;
    pass   = 0;
    while (placed < held_cnt && pass < MAX_JOBS) begin
      last_fin = -1;
      for (int k = 0; k < held_cnt; k++) begin
        idx = order[k];
        s   = held_start[idx];
        if (!taken[idx] && s > last_fin) begin
          taken[idx]   = 1'b1;
          last_fin     = held_finish[idx];
          placed++;
          rec.job_id   = held_id[idx];
          rec.row      = ROW_W'(pass);
          rec.start_t  = held_start[idx];
          rec.finish_t = held_finish[idx];
          rec.overflow = jobs_dropped;
          rec.last     = 1'b0;
          placement_q  = {placement_q, rec};
        end
      end
      pass++;
    end
    if (placed > 0) placement_q[$].last = 1'b1;
  endfunction

  function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      fail_cnt++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    placement_t want;
    if (!rst_ni) begin
      placement_q.delete();
      held_cnt     = 0;
      jobs_dropped = 1'b0;
      fail_cnt     = 0;
      checked_cnt  = 0;
      set_cnt      = 0;
      full_set_cnt = 0;
      pending_o    = 0;
    end else begin
      if (valid_i === 1'b1) begin
        if (placement_q.size() == 0) begin
          fail_cnt++;
          $display("%0t: result with nothing expected, actual id %0d row %0d",
                   $time, out_job_id_i, row_i);
        end else begin
          want = placement_q.pop_front();
          checked_cnt++;
          check_field("job id", 32'(want.job_id), 32'(out_job_id_i));
          check_field("row", 32'(want.row), 32'(row_i));
          check_field("start", 32'(want.start_t), 32'(out_start_i));
          check_field("finish", 32'(want.finish_t), 32'(out_finish_i));
          check_field("overflow", 32'(want.overflow), 32'(overflow_i));
          check_field("last result", 32'(want.last), 32'(last_result_i));
        end
      end
      if (start_i === 1'b1 && busy_i === 1'b0) begin
        if (held_cnt < MAX_JOBS) begin
          held_start[held_cnt]  = start_time_i;
          held_finish[held_cnt] = finish_time_i;
          held_id[held_cnt]     = job_id_i;
          held_cnt++;
        end else begin
          jobs_dropped = 1'b1;
        end
        if (last_job_i === 1'b1) begin
          plan_rows();
          set_cnt++;
          if (jobs_dropped) full_set_cnt++;
          held_cnt     = 0;
          jobs_dropped = 1'b0;
        end
      end
      pending_o = placement_q.size();
    end
  end

endmodule

@@ tb/interval_partition_scheduler_unit_tb.sv @@
// testbench top for the interval partition scheduler: request stimulus and verdict
module interval_partition_scheduler_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ips_pkg::*;

  // no-progress limit: room for a full 16-job schedule plus sender gaps
  localparam int STALL_LIMIT   = 4000;
  localparam int RANDOM_ITEMS  = 336;
  localparam int SETTLE_CYCLES = 40;

  // how tightly the random job times are packed inside one set
  typedef enum int {SPREAD_DENSE, SPREAD_WIDE, SPREAD_EDGE} spread_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  logic [IN_TIME_W-1:0]  start_time_i;
  logic [IN_TIME_W-1:0]  finish_time_i;
  logic [ID_W-1:0]       job_id_i;
  logic                  last_job_i;
  logic                  valid_o;
  logic [ID_W-1:0]       out_job_id_o;
  logic [ROW_W-1:0]      row_o;
  logic [OUT_TIME_W-1:0] out_start_o;
  logic [OUT_TIME_W-1:0] out_finish_o;
  logic                  overflow_o;
  logic                  last_result_o;

  int fail_count, pending, checked, sets, full_sets;
  int requests_sent;
  int idle_pct;

  interval_partition_scheduler_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .start_time_i  (start_time_i),
    .finish_time_i (finish_time_i),
    .job_id_i      (job_id_i),
    .last_job_i    (last_job_i),
    .valid_o       (valid_o),
    .out_job_id_o  (out_job_id_o),
    .row_o         (row_o),
    .out_start_o   (out_start_o),
    .out_finish_o  (out_finish_o),
    .overflow_o    (overflow_o),
    .last_result_o (last_result_o)
  );

  // the checker sees both channels exactly as the block does
  ips_schedule_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_i        (busy_o),
    .start_time_i  (start_time_i),
    .finish_time_i (finish_time_i),
    .job_id_i      (job_id_i),
    .last_job_i    (last_job_i),
    .valid_i       (valid_o),
    .out_job_id_i  (out_job_id_o),
    .row_i         (row_o),
    .out_start_i   (out_start_o),
    .out_finish_i  (out_finish_o),
    .overflow_i    (overflow_o),
    .last_result_i (last_result_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked),
    .sets_o        (sets),
    .full_sets_o   (full_sets)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // one request: optional random gap, then hold start_i until the block takes it
  // called and returning on a falling edge, so start_i is written once per step
  task automatic issue_job(input logic [IN_TIME_W-1:0] s, input logic [IN_TIME_W-1:0] f,
                           input logic [ID_W-1:0] id, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i       <= 1'b1;
    start_time_i  <= s;
    finish_time_i <= f;
    job_id_i      <= id;
    last_job_i    <= last;
    // accepted on the rising edge where busy_o is low
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    @(negedge clk_i);
    requests_sent++;
  endtask

  // sender holds off until every predicted placement has come back
  task automatic drain_results();
    start_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  function automatic logic [IN_TIME_W-1:0] pick_start(spread_e spread);
    case (spread)
      SPREAD_DENSE: return IN_TIME_W'($urandom_range(63));
      SPREAD_WIDE:  return IN_TIME_W'($urandom_range(65535));
      default:      return $urandom_range(1) ? IN_TIME_W'($urandom_range(15))
                                             : IN_TIME_W'(65535 - $urandom_range(15));
    endcase
  endfunction

  // mostly finish at or after start, sometimes equal, sometimes below start
  function automatic logic [IN_TIME_W-1:0] pick_finish(logic [IN_TIME_W-1:0] s,
                                                      spread_e spread);
    int unsigned r, len, sum;
    r = $urandom_range(99);
    if (r < 8) return (s == 0) ? '0 : IN_TIME_W'($urandom_range(s - 1));
    if (r < 16) return s;
    case (spread)
      SPREAD_DENSE: len = $urandom_range(1, 24);
      SPREAD_WIDE:  len = $urandom_range(65535);
      default:      len = $urandom_range(1, 40);
    endcase
    sum = s + len;
    return (sum > 65535) ? 16'hFFFF : sum[IN_TIME_W-1:0];
  endfunction

  // no-progress watchdog: neither a request nor a result taken for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if (rst_ni !== 1'b1 || (start_i === 1'b1 && busy_o === 1'b0) || valid_o === 1'b1)
        quiet = 0;
      else
        quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    int            set_size, r, phase, last_phase, rand_sent;
    spread_e       spread;
    logic [IN_TIME_W-1:0] s, f;
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    start_time_i  = '0;
    finish_time_i = '0;
    job_id_i      = '0;
    last_job_i    = 1'b0;
    requests_sent = 0;
    idle_pct      = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // single job set spanning the whole time range, extreme id
    issue_job(16'h0000, 16'hFFFF, 8'hFF, 1'b1);

    // ties on finish and start, start equal to a taken finish, max times, finish below start
    issue_job(16'd10, 16'd20, 8'h01, 1'b0);
    issue_job(16'd10, 16'd20, 8'h02, 1'b0);
    issue_job(16'd21, 16'd30, 8'h03, 1'b0);
    issue_job(16'd20, 16'd25, 8'h04, 1'b0);
    issue_job(16'hFFFF, 16'hFFFF, 8'hAA, 1'b0);
    issue_job(16'd40, 16'd5, 8'h55, 1'b0);
    issue_job(16'h0000, 16'h0000, 8'h00, 1'b1);

    // capacity full: sixteen jobs, then the last one is dropped but still starts the schedule
    for (int i = 0; i < 16; i++)
      issue_job(IN_TIME_W'(i * 16'h1111), IN_TIME_W'(i * 16'h1111 + 16'h0800),
                ID_W'(8'hF0 | i), 1'b0);
    issue_job(16'h1234, 16'h5678, 8'hEE, 1'b1);

    // random job sets in three sender phases: back to back, 60% idle, 28% idle
    rand_sent  = 0;
    last_phase = -1;
    while (rand_sent < RANDOM_ITEMS) begin
      phase = rand_sent * 3 / RANDOM_ITEMS;
      if (phase != last_phase) begin
        drain_results();
        @(negedge clk_i);
        idle_pct   = (phase == 0) ? 0 : (phase == 1) ? 60 : 28;
        last_phase = phase;
      end
      // mostly partial sets, some exactly full, a few past capacity
      r = $urandom_range(99);
      if (r < 8)
        set_size = $urandom_range(17, 20);
      else if (r < 18)
        set_size = 16;
      else
        set_size = $urandom_range(1, 15);
      r = $urandom_range(99);
      spread = (r < 50) ? SPREAD_DENSE : (r < 80) ? SPREAD_WIDE : SPREAD_EDGE;
      for (int i = 0; i < set_size; i++) begin
        s = pick_start(spread);
        f = pick_finish(s, spread);
        issue_job(s, f, ID_W'($urandom_range(255)), i == set_size - 1);
      end
      rand_sent += set_size;
    end

    // wrap up: everything back, block idle, then a short settle
    drain_results();
    while (busy_o !== 1'b0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    $display("sent %0d requests in %0d job sets, %0d of them past capacity",
             requests_sent, sets, full_sets);
    $display("checked %0d placements over three sender idle phases", checked);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
